// ===== hw/rtl/kclc_pkg.sv =====
// Shared types and constants for the keypad code lock controller.
`default_nettype none

package kclc_pkg;

  // Number of digits in the lock code
  localparam int unsigned CodeLen = 4;
  // Width of a digit index into the entry buffer
  localparam int unsigned IdxW = (CodeLen > 1) ? $clog2(CodeLen) : 1;
  // Digit count width, as wide as the digits_shown field
  localparam int unsigned CntW = 3;
  // Timer and register widths
  localparam int unsigned TimerW = 16;
  localparam int unsigned TempW = 12;

  // Decoded operation carried from the front end to the back end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_BUTTON,
    OP_MODE,
    OP_DIGIT,
    OP_CLEAR,
    OP_ENTER
  } op_e;

  // One queued request
  typedef struct packed {
    op_e              op;
    logic [3:0]       digit;
    logic             gas;
    logic [TempW-1:0] temp;
  } req_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // A zero duration counts as a single tick
  function automatic logic [TimerW-1:0] at_least_one(input logic [TimerW-1:0] t);
    return (t == '0) ? TimerW'(1) : t;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kclc_front.sv =====
// Front end: accepts input requests and decodes them into operations.
`default_nettype none

module kclc_front (
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [4:0]                  key_code_i,
  input  wire logic                        gas_detected_i,
  input  wire logic [kclc_pkg::TempW-1:0]  temp_code_i,
  input  wire kclc_pkg::q_stat_t           q_stat_i,
  output logic                             push_o,
  output kclc_pkg::req_t                   push_req_o
);

  localparam logic [1:0] CmdKey    = 2'd0;
  localparam logic [1:0] CmdTick   = 2'd1;
  localparam logic [1:0] CmdButton = 2'd2;
  localparam logic [4:0] KeyClear  = 5'd14;
  localparam logic [4:0] KeyEnter  = 5'd15;
  localparam logic [4:0] KeyMode   = 5'd16;
  localparam logic [4:0] KeyNine   = 5'd9;

  kclc_pkg::op_e op;

  // Hold off the sender while the queue is full
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Decode command and key into one operation
  always_comb begin
    op = kclc_pkg::OP_NOP;
    case (command_i)
      CmdTick:   op = kclc_pkg::OP_TICK;
      CmdButton: op = kclc_pkg::OP_BUTTON;
      CmdKey: begin
        if (key_code_i <= KeyNine) begin
          op = kclc_pkg::OP_DIGIT;
        end else if (key_code_i == KeyClear) begin
          op = kclc_pkg::OP_CLEAR;
        end else if (key_code_i == KeyEnter) begin
          op = kclc_pkg::OP_ENTER;
        end else if (key_code_i == KeyMode) begin
          op = kclc_pkg::OP_MODE;
        end
      end
      default:   op = kclc_pkg::OP_NOP;
    endcase
  end

  assign push_req_o.op    = op;
  assign push_req_o.digit = key_code_i[3:0];
  assign push_req_o.gas   = gas_detected_i;
  assign push_req_o.temp  = temp_code_i;

endmodule

`default_nettype wire

// ===== hw/rtl/kclc_queue.sv =====
// Two-entry request queue between the front and back ends.
`default_nettype none

module kclc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire kclc_pkg::req_t     push_req_i,
  input  wire logic               pop_i,
  output kclc_pkg::req_t          pop_req_o,
  output kclc_pkg::q_stat_t       q_stat_o
);

  kclc_pkg::req_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  assign pop_req_o          = mem_q[rd_ptr_q];
  assign q_stat_o.full      = count_q[1];
  assign q_stat_o.not_empty = (count_q != 2'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/kclc_back.sv =====
// Back end: lock state, timers, configuration and the result register.
`default_nettype none

module kclc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire kclc_pkg::q_stat_t             q_stat_i,
  input  wire kclc_pkg::req_t                req_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               lock_on_o,
  output logic                               buzzer_on_o,
  output logic [2:0]                         screen_o,
  output logic [2:0]                         digits_shown_o,
  output logic                               entry_active_o
);

  localparam int unsigned TW = kclc_pkg::TimerW;
  localparam int unsigned ExtW = (4 * kclc_pkg::CodeLen > 16) ? 4 * kclc_pkg::CodeLen : 16;

  localparam logic [2:0] RegCode  = 3'd0;
  localparam logic [2:0] RegOpen  = 3'd1;
  localparam logic [2:0] RegWrong = 3'd2;
  localparam logic [2:0] RegShort = 3'd3;
  localparam logic [2:0] RegAlarm = 3'd4;
  localparam logic [2:0] RegTemp  = 3'd5;

  localparam logic [2:0] ScrStatus = 3'd0;
  localparam logic [2:0] ScrEnter  = 3'd1;
  localparam logic [2:0] ScrOpen   = 3'd2;
  localparam logic [2:0] ScrWrong  = 3'd3;
  localparam logic [2:0] ScrShort  = 3'd4;

  localparam logic [kclc_pkg::CntW-1:0] FullCnt = kclc_pkg::CntW'(kclc_pkg::CodeLen);

  // Configuration registers
  logic [15:0]                code_q;
  logic [TW-1:0]              open_q, wrong_q, short_q, alarm_q;
  logic [kclc_pkg::TempW-1:0] limit_q;

  // Lock state
  logic                       entry_q, entry_d;
  logic [kclc_pkg::CntW-1:0]  count_q, count_d;
  logic [3:0]                 digits_q [kclc_pkg::CodeLen];
  logic [3:0]                 digits_d [kclc_pkg::CodeLen];
  logic [TW-1:0]              lock_tmr_q, lock_tmr_d;
  logic [TW-1:0]              scr_tmr_q, scr_tmr_d;
  logic [TW-1:0]              alarm_tmr_q, alarm_tmr_d;
  logic [2:0]                 screen_q, screen_d;
  logic                       buzz_q, buzz_d;

  logic                       out_valid_q;
  logic                       busy;
  logic                       match;
  logic [ExtW-1:0]            code_ext;
  logic                       buzz_out;

  // Take a request when the result register is free or being drained
  assign pop_o = q_stat_i.not_empty && (!out_valid_q || !out_stall_i);
  assign busy  = (lock_tmr_q != '0) || (scr_tmr_q != '0);

  // Compare entered digits against the stored code, first digit in the top nibble
  assign code_ext = ExtW'(code_q);
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < kclc_pkg::CodeLen; i++) begin
      if (digits_q[i] != code_ext[4 * (kclc_pkg::CodeLen - 1 - i) +: 4]) begin
        match = 1'b0;
      end
    end
  end

  // Next state for the request at the head of the queue
  always_comb begin
    entry_d     = entry_q;
    count_d     = count_q;
    digits_d    = digits_q;
    lock_tmr_d  = lock_tmr_q;
    scr_tmr_d   = scr_tmr_q;
    alarm_tmr_d = alarm_tmr_q;
    screen_d    = screen_q;
    buzz_d      = buzz_q;
    if (req_i.op == kclc_pkg::OP_TICK) begin
      if (lock_tmr_q != '0) begin
        lock_tmr_d = lock_tmr_q - TW'(1);
        if (lock_tmr_q == TW'(1)) begin
          screen_d = ScrStatus;
        end
      end
      if (scr_tmr_q != '0) begin
        scr_tmr_d = scr_tmr_q - TW'(1);
        if (scr_tmr_q == TW'(1)) begin
          screen_d = ScrEnter;
        end
      end
      if (alarm_tmr_q != '0) begin
        alarm_tmr_d = alarm_tmr_q - TW'(1);
        if (alarm_tmr_q == TW'(1)) begin
          buzz_d = 1'b0;
        end
      end
    end else if (!busy) begin
      case (req_i.op)
        kclc_pkg::OP_BUTTON: begin
          lock_tmr_d = kclc_pkg::at_least_one(open_q);
          screen_d   = ScrOpen;
        end
        kclc_pkg::OP_MODE: begin
          entry_d  = !entry_q;
          count_d  = '0;
          digits_d = '{default: 4'd0};
          screen_d = entry_q ? ScrStatus : ScrEnter;
        end
        kclc_pkg::OP_DIGIT: begin
          if (entry_q) begin
            if (count_q < FullCnt) begin
              digits_d[count_q[kclc_pkg::IdxW-1:0]] = req_i.digit;
              count_d = count_q + kclc_pkg::CntW'(1);
            end
            screen_d = ScrEnter;
          end
        end
        kclc_pkg::OP_CLEAR: begin
          if (entry_q) begin
            count_d  = '0;
            digits_d = '{default: 4'd0};
            screen_d = ScrEnter;
          end
        end
        kclc_pkg::OP_ENTER: begin
          if (entry_q) begin
            if (count_q == FullCnt) begin
              if (match) begin
                lock_tmr_d = kclc_pkg::at_least_one(open_q);
                screen_d   = ScrOpen;
                entry_d    = 1'b0;
              end else begin
                buzz_d      = 1'b1;
                alarm_tmr_d = kclc_pkg::at_least_one(alarm_q);
                scr_tmr_d   = kclc_pkg::at_least_one(wrong_q);
                screen_d    = ScrWrong;
              end
            end else begin
              scr_tmr_d = kclc_pkg::at_least_one(short_q);
              screen_d  = ScrShort;
            end
            count_d  = '0;
            digits_d = '{default: 4'd0};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Buzzer follows the alarm in entry mode, the sensors otherwise
  assign buzz_out = entry_d ? buzz_d : (req_i.gas || (req_i.temp > limit_q));

  // Hold configuration and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= 16'h1234;
      open_q      <= TW'(3000);
      wrong_q     <= TW'(2000);
      short_q     <= TW'(1500);
      alarm_q     <= TW'(10000);
      limit_q     <= kclc_pkg::TempW'(496);
      entry_q     <= 1'b0;
      count_q     <= '0;
      digits_q    <= '{default: 4'd0};
      lock_tmr_q  <= '0;
      scr_tmr_q   <= '0;
      alarm_tmr_q <= '0;
      screen_q    <= ScrStatus;
      buzz_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCode:  code_q  <= cfg_data_i;
          RegOpen:  open_q  <= cfg_data_i;
          RegWrong: wrong_q <= cfg_data_i;
          RegShort: short_q <= cfg_data_i;
          RegAlarm: alarm_q <= cfg_data_i;
          RegTemp:  limit_q <= cfg_data_i[kclc_pkg::TempW-1:0];
          default: begin
          end
        endcase
      end
      if (pop_o) begin
        entry_q     <= entry_d;
        count_q     <= count_d;
        digits_q    <= digits_d;
        lock_tmr_q  <= lock_tmr_d;
        scr_tmr_q   <= scr_tmr_d;
        alarm_tmr_q <= alarm_tmr_d;
        screen_q    <= screen_d;
        buzz_q      <= buzz_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lock_on_o      <= (lock_tmr_d != '0);
      buzzer_on_o    <= buzz_out;
      screen_o       <= screen_d;
      digits_shown_o <= count_d;
      entry_active_o <= entry_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_code_lock_controller_top.sv =====
// Top level of the keypad code lock controller.
//
// Input channel: one request per event (key press, timer tick or open
// button) with the current gas and temperature readings, taken when
// in_valid_i is high and in_stall_o is low. Output channel: one result per
// request (lock, buzzer, screen code, digit count, entry flag), taken when
// out_valid_o is high and out_stall_i is low; results keep request order.
// A request is decoded into a two-entry queue, then the back end
// updates the lock state and loads the result register. Throughput is
// one request per cycle while out_stall_i does not hold the result
// register. A stalled result holds in its register; the queue keeps taking
// requests until it fills, then in_stall_o rises. Configuration writes go
// through cfg_we_i, cfg_idx_i and cfg_data_i; the user must make them only
// while no request is in flight, as the block does not enforce it.
// Reset clears the queue, the lock state and timers, and loads the default
// code and durations; no result is pending after reset.
`default_nettype none

module keypad_code_lock_controller_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [4:0]  key_code_i,
  input  wire logic        gas_detected_i,
  input  wire logic [11:0] temp_code_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             lock_on_o,
  output logic             buzzer_on_o,
  output logic [2:0]       screen_o,
  output logic [2:0]       digits_shown_o,
  output logic             entry_active_o
);

  kclc_pkg::q_stat_t q_stat;
  kclc_pkg::req_t    push_req;
  kclc_pkg::req_t    pop_req;
  logic              push;
  logic              pop;

  // Decode incoming requests
  kclc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .key_code_i     (key_code_i),
    .gas_detected_i (gas_detected_i),
    .temp_code_i    (temp_code_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_req_o     (push_req)
  );

  // Buffer decoded requests
  kclc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .pop_req_o  (pop_req),
    .q_stat_o   (q_stat)
  );

  // Execute requests and drive results
  kclc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .q_stat_i       (q_stat),
    .req_i          (pop_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lock_on_o      (lock_on_o),
    .buzzer_on_o    (buzzer_on_o),
    .screen_o       (screen_o),
    .digits_shown_o (digits_shown_o),
    .entry_active_o (entry_active_o)
  );

endmodule

`default_nettype wire
